// File: src/dnp_pkg.sv
// shared types, codes and constants of the decimal number parser
package dnp_pkg;

  // field limits
  localparam int MAX_CHARS       = 64;
  localparam int MAX_SIG_DIGITS  = 18;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [6:0]  POS_UNSET     = 7'h7F;
  localparam logic [16:0] EXP_CAP       = 17'd99999;
  localparam logic [59:0] ESD_CAP       = 60'd999999999999999999;
  // above this an esd digit pushes the value past the cap
  localparam logic [59:0] ESD_SAT_LIMIT = 60'd99999999999999999;

  // character classes, digits keep their own value 0..9
  typedef logic [4:0] sym_t;
  localparam sym_t SYM_PLUS   = 5'd10;
  localparam sym_t SYM_POINT  = 5'd11;
  localparam sym_t SYM_MINUS  = 5'd12;
  localparam sym_t SYM_LPAREN = 5'd13;
  localparam sym_t SYM_RPAREN = 5'd14;
  localparam sym_t SYM_UC_E   = 5'd15;
  localparam sym_t SYM_UC_D   = 5'd16;
  localparam sym_t SYM_UC_Q   = 5'd17;
  localparam sym_t SYM_LC_E   = 5'd18;
  localparam sym_t SYM_LC_D   = 5'd19;
  localparam sym_t SYM_LC_Q   = 5'd20;
  localparam sym_t SYM_SPACE  = 5'd21;
  localparam sym_t SYM_OTHER  = 5'd22;

  // seen flag bit positions
  localparam int SEEN_LETTER = 0;
  localparam int SEEN_ESIGN  = 1;
  localparam int SEEN_MSIGN  = 2;

  // range warning codes
  typedef logic [1:0] warn_t;
  localparam warn_t WARN_NONE  = 2'd0;
  localparam warn_t WARN_OVER  = 2'd1;
  localparam warn_t WARN_UNDER = 2'd2;

  // configuration register indexes
  localparam logic CFG_MIN_EXP = 1'b0;
  localparam logic CFG_MAX_EXP = 1'b1;

  // scan phases
  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_INT  = 3'd1,
    PH_FRAC = 3'd2,
    PH_EXP  = 3'd3,
    PH_ESD  = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic               is_number;
    logic               negative;
    logic [59:0]        significand;
    logic [6:0]         dropped_digits;
    logic signed [11:0] decimal_exponent;
    logic               has_esd;
    logic [59:0]        esd_value;
    logic [6:0]         esd_digits;
    logic [6:0]         point_pos;
    logic               has_point;
    logic               leading_zero;
    logic [1:0]         range_warning;
  } out_t;

  // classified character between front and scanner
  typedef struct packed {
    sym_t sym;
    logic nul;
    logic last;
  } cls_t;

  // finished field state handed from scanner to exponent stages
  typedef struct packed {
    logic        reject;
    logic        negative;
    logic [59:0] significand;
    logic [6:0]  dropped;
    logic [6:0]  int_cnt;
    logic [6:0]  frac_cnt;
    logic [16:0] exp_val;
    logic        exp_neg;
    logic [6:0]  esd_cnt;
    logic [59:0] esd_val;
    logic [6:0]  point_pos;
    logic        has_point;
    logic        lzero;
  } fin_t;

  // map one ASCII character to its class
  function automatic sym_t sym_of(input logic [7:0] c);
    sym_t s;
    begin
      s = SYM_OTHER;
      if (c >= 8'h30 && c <= 8'h39) begin
        s = sym_t'(c - 8'h30);
      end else begin
        unique case (c)
          8'h2B:   s = SYM_PLUS;
          8'h2E:   s = SYM_POINT;
          8'h2D:   s = SYM_MINUS;
          8'h28:   s = SYM_LPAREN;
          8'h29:   s = SYM_RPAREN;
          8'h45:   s = SYM_UC_E;
          8'h44:   s = SYM_UC_D;
          8'h51:   s = SYM_UC_Q;
          8'h65:   s = SYM_LC_E;
          8'h64:   s = SYM_LC_D;
          8'h71:   s = SYM_LC_Q;
          8'h20:   s = SYM_SPACE;
          default: s = SYM_OTHER;
        endcase
      end
      return s;
    end
  endfunction

endpackage

// File: src/dnp_front.sv
// front end: takes character requests and classifies them for the queue
module dnp_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  dnp_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output dnp_pkg::cls_t push_item
);
  import dnp_pkg::*;

  // handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // character class lookup
  always_comb begin
    push_item.sym  = sym_of(in_data.char_code);
    push_item.nul  = (in_data.char_code == 8'h00);
    push_item.last = in_data.last_char;
  end

endmodule

// File: src/dnp_queue.sv
// short queue of classified characters between front and scanner
module dnp_queue #(
  parameter int DEPTH = dnp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dnp_pkg::cls_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dnp_pkg::cls_t pop_item
);
  import dnp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule

// File: src/dnp_scan.sv
// scanner: scans one character per cycle, a last one when fin_ready
module dnp_scan (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  dnp_pkg::cls_t q_item,
  output logic          fin_valid,
  input  logic          fin_ready,
  output dnp_pkg::fin_t fin_data
);
  import dnp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        rej_r, rej_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [59:0] mant_r, mant_nxt;
  logic [4:0]  sig_r, sig_nxt;
  logic [6:0]  mdig_r, mdig_nxt;
  logic [6:0]  frac_r, frac_nxt;
  logic [6:0]  int_r, int_nxt;
  logic [6:0]  drop_r, drop_nxt;
  logic        mneg_r, mneg_nxt;
  logic [16:0] exp_r, exp_nxt;
  logic        eneg_r, eneg_nxt;
  logic [6:0]  ecnt_r, ecnt_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [59:0] esd_r, esd_nxt;
  logic [6:0]  esdc_r, esdc_nxt;
  logic [6:0]  ppos_r, ppos_nxt;
  logic        hpt_r, hpt_nxt;
  logic        lz_r, lz_nxt;
  logic        pzero_r, pzero_nxt;

  sym_t        m;
  logic        pop, is_dig, is_letter, is_sign;
  logic        active, first_rej, live, stop_now, go, sym_rej, char_ok;
  phase_t      ph_dig;
  logic [59:0] mant_x10, esd_x10;
  logic [19:0] exp_x10;
  logic        mant_full;

  // character decode
  assign m         = q_item.sym;
  assign is_dig    = (m < SYM_PLUS);
  assign is_letter = (m >= SYM_UC_E) && (m <= SYM_LC_Q);
  assign is_sign   = (m == SYM_PLUS) || (m == SYM_MINUS);

  // handshake: a last character waits for the exponent stages
  assign q_ready   = !q_item.last || fin_ready;
  assign pop       = q_valid && q_ready;
  assign fin_valid = pop && q_item.last;

  // scan gating
  assign active    = !rej_r && (phase_r != PH_STOP);
  assign first_rej = active && (pos_r == '0) && q_item.last && !is_dig;
  assign live      = active && !first_rej;
  assign stop_now  = live && (q_item.nul || (pos_r >= 7'(MAX_CHARS)));
  assign go        = live && !stop_now;
  assign ph_dig    = (phase_r == PH_SEEK) ? PH_INT : phase_r;

  // malformed character checks
  always_comb begin
    sym_rej = 1'b0;
    if (m == SYM_OTHER) begin
      sym_rej = 1'b1;
    end else if (m == SYM_POINT) begin
      sym_rej = (phase_r > PH_INT);
    end else if (!is_dig) begin
      if (mdig_r == '0 && m > SYM_MINUS && m != SYM_SPACE) begin
        sym_rej = 1'b1;
      end else if (is_letter || is_sign) begin
        if (phase_r == PH_EXP && ecnt_r != '0) begin
          sym_rej = 1'b1;
        end else if (is_letter) begin
          sym_rej = seen_r[SEEN_LETTER];
        end else if (phase_r != PH_SEEK) begin
          sym_rej = seen_r[SEEN_ESIGN];
        end else begin
          sym_rej = seen_r[SEEN_MSIGN];
        end
      end
    end
  end

  assign char_ok = go && !sym_rej;

  // shift-add by ten for the three accumulators
  assign mant_x10  = {mant_r[56:0], 3'b000} + {mant_r[58:0], 1'b0} + 60'(m[3:0]);
  assign esd_x10   = {esd_r[56:0], 3'b000} + {esd_r[58:0], 1'b0} + 60'(m[3:0]);
  assign exp_x10   = {exp_r, 3'b000} + 20'({exp_r, 1'b0}) + 20'(m[3:0]);
  assign mant_full = (mant_r != '0) && (sig_r >= 5'(MAX_SIG_DIGITS));

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (stop_now) begin
      phase_nxt = PH_STOP;
    end else if (char_ok) begin
      if (is_dig) begin
        phase_nxt = ph_dig;
      end else if (m == SYM_POINT) begin
        phase_nxt = PH_FRAC;
      end else if (m == SYM_LPAREN) begin
        phase_nxt = PH_ESD;
      end else if (is_letter) begin
        phase_nxt = PH_EXP;
      end else if (is_sign) begin
        phase_nxt = (phase_r != PH_SEEK) ? PH_EXP : PH_INT;
      end
    end
  end

  // field state update
  always_comb begin
    rej_nxt   = rej_r || first_rej || (go && sym_rej);
    pos_nxt   = pos_r;
    mant_nxt  = mant_r;
    sig_nxt   = sig_r;
    mdig_nxt  = mdig_r;
    frac_nxt  = frac_r;
    int_nxt   = int_r;
    drop_nxt  = drop_r;
    mneg_nxt  = mneg_r;
    exp_nxt   = exp_r;
    eneg_nxt  = eneg_r;
    ecnt_nxt  = ecnt_r;
    seen_nxt  = seen_r;
    esd_nxt   = esd_r;
    esdc_nxt  = esdc_r;
    ppos_nxt  = ppos_r;
    hpt_nxt   = hpt_r;
    lz_nxt    = lz_r;
    pzero_nxt = pzero_r;
    if (char_ok) begin
      pos_nxt   = pos_r + 1'b1;
      pzero_nxt = (m == 5'd0);
      if (is_dig) begin
        // digit into mantissa, exponent or esd
        if (ph_dig == PH_INT || ph_dig == PH_FRAC) begin
          if (mant_full) begin
            if (ph_dig == PH_INT) begin
              drop_nxt = drop_r + 1'b1;
              int_nxt  = int_r + 1'b1;
            end
          end else begin
            mant_nxt = mant_x10;
            if (mant_x10 != '0) begin
              sig_nxt = sig_r + 1'b1;
            end
            if (ph_dig == PH_FRAC) begin
              frac_nxt = frac_r + 1'b1;
            end
            if (ph_dig == PH_INT && mant_x10 != '0) begin
              int_nxt = int_r + 1'b1;
            end
          end
          mdig_nxt = mdig_r + 1'b1;
        end else if (ph_dig == PH_EXP) begin
          ecnt_nxt = ecnt_r + 1'b1;
          exp_nxt  = (exp_x10 > 20'(EXP_CAP)) ? EXP_CAP : exp_x10[16:0];
        end else begin
          esdc_nxt = esdc_r + 1'b1;
          esd_nxt  = (esd_r > ESD_SAT_LIMIT) ? ESD_CAP : esd_x10;
        end
      end else if (m == SYM_POINT) begin
        // decimal point
        hpt_nxt  = 1'b1;
        ppos_nxt = pos_r;
        if (pos_r != '0 && mant_r == '0 && pzero_r) begin
          lz_nxt = 1'b1;
        end
      end else if (m == SYM_LPAREN) begin
        if (ppos_r == POS_UNSET) begin
          ppos_nxt = pos_r;
        end
      end else begin
        // mantissa ends at the first other symbol
        if (ppos_r == POS_UNSET && phase_r != PH_SEEK) begin
          ppos_nxt = pos_r;
        end
        if (is_letter) begin
          seen_nxt[SEEN_LETTER] = 1'b1;
          eneg_nxt = 1'b0;
        end else if (is_sign && phase_r != PH_SEEK) begin
          seen_nxt[SEEN_ESIGN] = 1'b1;
          eneg_nxt = (m == SYM_MINUS);
        end else if (is_sign) begin
          seen_nxt[SEEN_MSIGN] = 1'b1;
          mneg_nxt = (m == SYM_MINUS);
        end
      end
    end
  end

  // finished field state
  always_comb begin
    fin_data.reject      = rej_nxt;
    fin_data.negative    = mneg_nxt;
    fin_data.significand = mant_nxt;
    fin_data.dropped     = drop_nxt;
    fin_data.int_cnt     = int_nxt;
    fin_data.frac_cnt    = frac_nxt;
    fin_data.exp_val     = exp_nxt;
    fin_data.exp_neg     = eneg_nxt;
    fin_data.esd_cnt     = esdc_nxt;
    fin_data.esd_val     = esd_nxt;
    fin_data.point_pos   = (ppos_nxt == POS_UNSET) ? pos_nxt : ppos_nxt;
    fin_data.has_point   = hpt_nxt;
    fin_data.lzero       = lz_nxt;
  end

  // scan registers, cleared at reset and after each field
  always_ff @(posedge clk) begin
    if (!rst_n || (pop && q_item.last)) begin
      phase_r <= PH_SEEK;
      rej_r   <= 1'b0;
      pos_r   <= '0;
      mant_r  <= '0;
      sig_r   <= '0;
      mdig_r  <= '0;
      frac_r  <= '0;
      int_r   <= '0;
      drop_r  <= '0;
      mneg_r  <= 1'b0;
      exp_r   <= '0;
      eneg_r  <= 1'b0;
      ecnt_r  <= '0;
      seen_r  <= '0;
      esd_r   <= '0;
      esdc_r  <= '0;
      ppos_r  <= POS_UNSET;
      hpt_r   <= 1'b0;
      lz_r    <= 1'b0;
      pzero_r <= 1'b0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      rej_r   <= rej_nxt;
      pos_r   <= pos_nxt;
      mant_r  <= mant_nxt;
      sig_r   <= sig_nxt;
      mdig_r  <= mdig_nxt;
      frac_r  <= frac_nxt;
      int_r   <= int_nxt;
      drop_r  <= drop_nxt;
      mneg_r  <= mneg_nxt;
      exp_r   <= exp_nxt;
      eneg_r  <= eneg_nxt;
      ecnt_r  <= ecnt_nxt;
      seen_r  <= seen_nxt;
      esd_r   <= esd_nxt;
      esdc_r  <= esdc_nxt;
      ppos_r  <= ppos_nxt;
      hpt_r   <= hpt_nxt;
      lz_r    <= lz_nxt;
      pzero_r <= pzero_nxt;
    end
  end

`ifndef SYNTHESIS
  a_field_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last) |=> (phase_r == PH_SEEK && pos_r == '0 && !rej_r))
    else $error("scan state not cleared after field end");
  a_point_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ppos_r != POS_UNSET) |-> (ppos_r < pos_r))
    else $error("point position not behind scan position");
`endif

endmodule

// File: src/dnp_finish.sv
// exponent stages: clamp against limits and register the result
module dnp_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fin_valid,
  output logic               fin_ready,
  input  dnp_pkg::fin_t      fin_data,
  input  logic signed [10:0] min_exp,
  input  logic [10:0]        max_exp,
  output logic               out_valid,
  input  logic               out_ready,
  output dnp_pkg::out_t      out_data
);
  import dnp_pkg::*;

  logic               a_v_r, a_v_nxt;
  fin_t               a_r;
  logic               b_v_r, b_v_nxt;
  fin_t               b_r;
  logic signed [18:0] b_e1_r;
  logic               b_ovf_r;
  logic               out_v_r, out_v_nxt;
  out_t               out_r, out_nxt;

  logic               c_take, b_adv, a_adv;
  logic signed [18:0] e_mag, e_sgn, e_sum, e_max, e_int, e1;
  logic               ovf, udf;
  logic signed [18:0] e_min, e2, e_out;

  // stage advance chain
  assign c_take    = !out_v_r || out_ready;
  assign b_adv     = !b_v_r || c_take;
  assign a_adv     = !a_v_r || b_adv;
  assign fin_ready = a_adv;
  assign a_v_nxt   = a_adv ? fin_valid : a_v_r;
  assign b_v_nxt   = b_adv ? a_v_r : b_v_r;
  assign out_v_nxt = c_take ? b_v_r : out_v_r;

  // overflow clamp on exponent plus integer digits
  always_comb begin
    e_mag = $signed({2'b00, a_r.exp_val});
    e_sgn = a_r.exp_neg ? -e_mag : e_mag;
    e_int = $signed({12'b0, a_r.int_cnt});
    e_sum = e_sgn + e_int;
    e_max = $signed({8'b0, max_exp});
    ovf   = (e_sum > e_max);
    e1    = ovf ? (e_max - e_int) : e_sgn;
  end

  // underflow clamp, fraction shift and result assembly
  always_comb begin
    e_min = {{8{min_exp[10]}}, min_exp};
    udf   = (b_e1_r < e_min);
    e2    = udf ? e_min : b_e1_r;
    e_out = e2 - $signed({12'b0, b_r.frac_cnt});
    out_nxt = '0;
    if (!b_r.reject) begin
      out_nxt.is_number        = 1'b1;
      out_nxt.negative         = b_r.negative;
      out_nxt.significand      = b_r.significand;
      out_nxt.dropped_digits   = b_r.dropped;
      out_nxt.decimal_exponent = e_out[11:0];
      out_nxt.has_esd          = (b_r.esd_cnt != '0);
      out_nxt.esd_value        = b_r.esd_val;
      out_nxt.esd_digits       = b_r.esd_cnt;
      out_nxt.point_pos        = b_r.point_pos;
      out_nxt.has_point        = b_r.has_point;
      out_nxt.leading_zero     = b_r.lzero;
      out_nxt.range_warning    = udf ? WARN_UNDER : (b_ovf_r ? WARN_OVER : WARN_NONE);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (a_adv && fin_valid) begin
      a_r <= fin_data;
    end
    if (b_adv && a_v_r) begin
      b_r     <= a_r;
      b_e1_r  <= e1;
      b_ovf_r <= ovf;
    end
    if (c_take && b_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.is_number) |->
      (out_r.significand == '0 && out_r.range_warning == WARN_NONE))
    else $error("rejected field carries nonzero result");
  a_warn_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.range_warning == WARN_NONE || out_r.range_warning == WARN_OVER ||
                 out_r.range_warning == WARN_UNDER))
    else $error("undefined range warning code");
`endif

endmodule

// File: src/decimal_number_with_esd_parser_top.sv
// top level of the decimal number with esd parser
//
// Characters of a numeric field arrive on the in_ channel (valid/ready), one
// request per character, last_char set on the final one. For each field one
// result request leaves on the out_ channel: the significand, esd and shared
// decimal exponent, or is_number low when the field is rejected as text.
// Characters are taken at one per cycle while the queue has room; a
// classified character sits in a small queue, the scanner consumes one per
// cycle unless a last character waits for the exponent stages, and two
// exponent stages follow it. The sustained rate of one character per cycle
// is set by the scanner's shift-add update of its state. When the receiver
// holds out_ready low, the result waits in the output register; the exponent
// stages and the queue keep filling, and in_ready drops only once the queue
// is full. cfg_we writes min_exponent (index 0) or max_exponent (index 1)
// from cfg_data; the user must write only while no field is in flight, as
// the block does not enforce it. Synchronous reset clears the scan state,
// queue and result valid and loads min_exponent = -307 and max_exponent = 308.
module decimal_number_with_esd_parser_top #(
  parameter int QUEUE_DEPTH = dnp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dnp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dnp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_data
);
  import dnp_pkg::*;

  logic               push_valid, push_ready;
  cls_t               push_item;
  logic               q_valid, q_ready;
  cls_t               q_item;
  logic               fin_valid, fin_ready;
  fin_t               fin_data;
  logic signed [10:0] min_exp_r;
  logic [10:0]        max_exp_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_exp_r <= -11'sd307;
      max_exp_r <= 11'd308;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_EXP: min_exp_r <= cfg_data;
        CFG_MAX_EXP: max_exp_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  dnp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dnp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  dnp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_data  (fin_data)
  );

  dnp_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_data  (fin_data),
    .min_exp   (min_exp_r),
    .max_exp   (max_exp_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/parse_check_pkg.sv
// expected-result model and scoreboard for the decimal number parser bench
package parse_check_pkg;
  import dnp_pkg::*;

  localparam int POS_NONE  = int'(POS_UNSET);
  localparam int EXP_LIMIT = int'(EXP_CAP);

  class number_scoreboard;
    // exponent limits as last programmed
    int lo_exp;
    int hi_exp;

    // scan state of the field in progress
    phase_t phase;
    bit rejected;
    bit prev_zero;
    bit mant_neg;
    bit exp_neg;
    bit got_point;
    bit lead_zero;
    bit [2:0] seen;
    int pos;
    int sig_cnt;
    int mant_cnt;
    int frac_cnt;
    int int_cnt;
    int drop_cnt;
    int exp_cnt;
    int exp_mag;
    int esd_cnt;
    int point_at;
    longint unsigned mant;
    longint unsigned esd_acc;

    // parsed fields still owed by the block, oldest first
    out_t owed_q[$];
    int errors;

    function new();
      lo_exp = -307;
      hi_exp = 308;
      errors = 0;
      clear_field();
    endfunction

    function void set_limits(int lo, int hi);
      lo_exp = lo;
      hi_exp = hi;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void clear_field();
      phase = PH_SEEK;
      rejected = 0;
      prev_zero = 0;
      mant_neg = 0;
      exp_neg = 0;
      got_point = 0;
      lead_zero = 0;
      seen = '0;
      pos = 0;
      sig_cnt = 0;
      mant_cnt = 0;
      frac_cnt = 0;
      int_cnt = 0;
      drop_cnt = 0;
      exp_cnt = 0;
      exp_mag = 0;
      esd_cnt = 0;
      point_at = POS_NONE;
      mant = 0;
      esd_acc = 0;
    endfunction

    // ascii to character class, digits map to their value
    function sym_t char_class(logic [7:0] c);
      if (c >= "0" && c <= "9") return sym_t'(c - "0");
      case (c)
        "+": return SYM_PLUS;
        "-": return SYM_MINUS;
        ".": return SYM_POINT;
        "(": return SYM_LPAREN;
        ")": return SYM_RPAREN;
        "E": return SYM_UC_E;
        "D": return SYM_UC_D;
        "Q": return SYM_UC_Q;
        "e": return SYM_LC_E;
        "d": return SYM_LC_D;
        "q": return SYM_LC_Q;
        " ": return SYM_SPACE;
        default: return SYM_OTHER;
      endcase
    endfunction

    // one digit into mantissa, exponent or esd
    function void take_digit(int d);
      longint unsigned dd;
      dd = longint'(d);
      if (phase == PH_SEEK) phase = PH_INT;
      if (phase == PH_INT || phase == PH_FRAC) begin
        if (mant != 0 && sig_cnt >= MAX_SIG_DIGITS) begin
          if (phase == PH_INT) drop_cnt++;
        end else begin
          mant = mant * 10 + dd;
          if (mant != 0) sig_cnt++;
          if (phase == PH_FRAC) frac_cnt++;
        end
        mant_cnt++;
        if (phase == PH_INT && mant != 0) int_cnt++;
      end else if (phase == PH_EXP) begin
        exp_cnt++;
        exp_mag = exp_mag * 10 + d;
        if (exp_mag > EXP_LIMIT) exp_mag = EXP_LIMIT;
      end else begin
        esd_cnt++;
        if (esd_acc > (64'(ESD_CAP) - dd) / 10) esd_acc = 64'(ESD_CAP);
        else esd_acc = esd_acc * 10 + dd;
      end
    endfunction

    // point, signs, letters, parentheses and space
    function void take_symbol(sym_t s);
      if (s == SYM_POINT) begin
        got_point = 1;
        if (pos > 0 && mant == 0 && prev_zero) lead_zero = 1;
        if (phase > PH_INT) begin
          rejected = 1;
          return;
        end
        point_at = pos;
        phase = PH_FRAC;
        return;
      end
      // parenthesis or letter with no mantissa digit yet
      if (mant_cnt == 0 && s > SYM_MINUS && s != SYM_SPACE) begin
        rejected = 1;
        return;
      end
      if (s == SYM_LPAREN) begin
        if (point_at == POS_NONE) point_at = pos;
        phase = PH_ESD;
        return;
      end
      if (point_at == POS_NONE && phase != PH_SEEK) point_at = pos;
      if (s == SYM_RPAREN || s == SYM_SPACE) return;
      // no sign or letter may follow exponent digits
      if (phase == PH_EXP && exp_cnt != 0) begin
        rejected = 1;
        return;
      end
      if (s > SYM_MINUS) begin
        if (seen[SEEN_LETTER]) begin
          rejected = 1;
          return;
        end
        seen[SEEN_LETTER] = 1;
        phase = PH_EXP;
        exp_neg = 0;
      end else if (phase != PH_SEEK) begin
        if (seen[SEEN_ESIGN]) begin
          rejected = 1;
          return;
        end
        seen[SEEN_ESIGN] = 1;
        phase = PH_EXP;
        exp_neg = (s == SYM_MINUS);
      end else begin
        if (seen[SEEN_MSIGN]) begin
          rejected = 1;
          return;
        end
        seen[SEEN_MSIGN] = 1;
        phase = PH_INT;
        mant_neg = (s == SYM_MINUS);
      end
    endfunction

    function void take_char(logic [7:0] c);
      sym_t s;
      s = char_class(c);
      if (s == SYM_OTHER) begin
        rejected = 1;
        return;
      end
      if (s < SYM_PLUS) take_digit(int'(s));
      else take_symbol(s);
      if (rejected) return;
      pos++;
      prev_zero = (s == sym_t'(0));
    endfunction

    // accepted character request; on the last one the field result is owed
    function void note_request(in_t r);
      out_t res;
      int e;
      warn_t warn;
      bit is_digit;
      is_digit = (r.char_code >= "0" && r.char_code <= "9");
      if (!rejected && phase != PH_STOP && pos == 0 && r.last_char && !is_digit)
        rejected = 1;
      if (!rejected && phase != PH_STOP) begin
        if (r.char_code == 8'h00 || pos >= MAX_CHARS) phase = PH_STOP;
        else take_char(r.char_code);
      end
      if (!r.last_char) return;
      res = '0;
      if (!rejected) begin
        e = exp_neg ? -exp_mag : exp_mag;
        warn = WARN_NONE;
        if (e + int_cnt > hi_exp) begin
          warn = WARN_OVER;
          e = hi_exp - int_cnt;
        end
        if (e < lo_exp) begin
          warn = WARN_UNDER;
          e = lo_exp;
        end
        e = e - frac_cnt;
        res.is_number = 1'b1;
        res.negative = mant_neg;
        res.significand = mant[59:0];
        res.dropped_digits = 7'(drop_cnt);
        res.decimal_exponent = 12'(e);
        res.has_esd = (esd_cnt != 0);
        res.esd_value = esd_acc[59:0];
        res.esd_digits = 7'(esd_cnt);
        res.point_pos = 7'((point_at == POS_NONE) ? pos : point_at);
        res.has_point = got_point;
        res.leading_zero = lead_zero;
        res.range_warning = warn;
      end
      owed_q.push_back(res);
      clear_field();
    endfunction

    function void cmp(string name, longint want, longint got);
      if (want != got) begin
        $error("field %s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // result request from the block against the oldest owed field
    function void check_result(out_t a);
      out_t w;
      if (owed_q.size() == 0) begin
        $error("result request with no field outstanding");
        errors++;
        return;
      end
      w = owed_q.pop_front();
      cmp("is_number", longint'(w.is_number), longint'(a.is_number));
      cmp("negative", longint'(w.negative), longint'(a.negative));
      cmp("significand", longint'(w.significand), longint'(a.significand));
      cmp("dropped_digits", longint'(w.dropped_digits), longint'(a.dropped_digits));
      cmp("decimal_exponent", longint'(w.decimal_exponent),
          longint'(a.decimal_exponent));
      cmp("has_esd", longint'(w.has_esd), longint'(a.has_esd));
      cmp("esd_value", longint'(w.esd_value), longint'(a.esd_value));
      cmp("esd_digits", longint'(w.esd_digits), longint'(a.esd_digits));
      cmp("point_pos", longint'(w.point_pos), longint'(a.point_pos));
      cmp("has_point", longint'(w.has_point), longint'(a.has_point));
      cmp("leading_zero", longint'(w.leading_zero), longint'(a.leading_zero));
      cmp("range_warning", longint'(w.range_warning), longint'(a.range_warning));
    endfunction
  endclass

endpackage

// File: bench/tb_decimal_number_with_esd_parser_top.sv
// bench top for the decimal number parser: directed and random fields, scoreboard
module tb_decimal_number_with_esd_parser_top;
  import dnp_pkg::*;
  import parse_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  in_t           in_data;
  logic          out_valid;
  logic          out_ready;
  out_t          out_data;
  logic          cfg_we;
  logic          cfg_index;
  logic [10:0]   cfg_data;

  number_scoreboard sb;
  logic [7:0] field_buf[$];
  int chars_sent = 0;
  int src_idle = 11;
  int sink_idle = 84;
  int cycles = 0;

  decimal_number_with_esd_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle);
  end

  // result requests
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // one character request, entered and left at a falling edge
  task automatic send_char(input in_t d);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(d);
    @(negedge clk);
  endtask

  task automatic send_field();
    in_t d;
    int i;
    for (i = 0; i < field_buf.size(); i++) begin
      d.char_code = field_buf[i];
      d.last_char = (i == field_buf.size() - 1);
      send_char(d);
      chars_sent++;
    end
    field_buf.delete();
  endtask

  // hold off until every owed result is back, then pause
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // both limit registers in back-to-back writes
  task automatic program_limits(input int lo, input int hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_EXP;
    cfg_data <= 11'(lo);
    @(negedge clk);
    cfg_index <= CFG_MAX_EXP;
    cfg_data <= 11'(hi);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(lo, hi);
  endtask

  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) field_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(input int n);
    int i;
    for (i = 0; i < n; i++) field_buf.push_back(8'("0" + $urandom_range(9)));
  endfunction

  // digit run length: mostly short, now and then past the significant limit
  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 75) return 0;
    if (r < 93) return $urandom_range(5, 12);
    return $urandom_range(13, 30);
  endfunction

  // random field: mostly well formed, some broken, some noise
  function automatic void build_field();
    string letters;
    string symbols;
    int kind;
    int r;
    int n;
    int at;
    bit lettered;
    logic [7:0] ch;
    letters = "EDQedq";
    symbols = "0123456789+.-()EDQedq ";
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
      repeat (n) field_buf.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(19) == 0) put_text(" ");
    r = $urandom_range(3);
    if (r == 0) put_text("+");
    else if (r == 1) put_text("-");
    if ($urandom_range(4) == 0) put_text("0");
    put_digits(pick_count());
    if ($urandom_range(1) == 1) begin
      put_text(".");
      put_digits(pick_count());
    end
    if ($urandom_range(3) != 0) begin
      lettered = ($urandom_range(2) != 0);
      if (lettered) field_buf.push_back(letters[$urandom_range(5)]);
      r = $urandom_range(2);
      if (!lettered || r != 0) put_text((r == 1) ? "-" : "+");
      put_digits(($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 6));
    end
    if ($urandom_range(2) == 0) begin
      put_text("(");
      put_digits(pick_count());
      if ($urandom_range(7) != 0) put_text(")");
    end
    if ($urandom_range(19) == 0) put_text(" ");
    if (field_buf.size() == 0) put_digits(1);
    // broken sequence: stray symbol or byte dropped in or over a character
    if (kind < 25) begin
      ch = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                    : symbols[$urandom_range(21)];
      at = $urandom_range(field_buf.size() - 1);
      if ($urandom_range(1) == 1) field_buf.insert(at, ch);
      else field_buf[at] = ch;
    end
  endfunction

  task automatic run_phase(input int src_pct, input int sink_pct, input int budget);
    int stop_at;
    stop_at = chars_sent + budget;
    src_idle = src_pct;
    sink_idle = sink_pct;
    while (chars_sent < stop_at) begin
      build_field();
      send_field();
      if ($urandom_range(39) == 0) wait_drained(0);
    end
  endtask

  task automatic directed_fields();
    int i;
    put_text("0");                      send_field();
    put_text("9");                      send_field();
    put_text("+");                      send_field();
    put_text(" 7 ");                    send_field();
    put_text("- ");                     send_field();
    put_text("-12.50e3(4)");            send_field();
    put_text("+0.0045E-12(123)");       send_field();
    put_text("00.1");                   send_field();
    put_text("1234567890123456789012"); send_field();
    put_text("0.12345678901234567890123"); send_field();
    put_text("1e999999");               send_field();
    put_text("1.5d-400");               send_field();
    put_text("99Q+0007");               send_field();
    put_text("7q-");                    send_field();
    put_text("1e2e3");                  send_field();
    put_text("1.2.3");                  send_field();
    put_text("--1");                    send_field();
    put_text("1(9999999999999999999999)"); send_field();
    put_text("1)2 ");                   send_field();
    put_text("(5)");                    send_field();
    put_text("E5");                     send_field();
    put_text("a1~");                    send_field();
    // scan ends at a nul byte
    put_text("12");
    field_buf.push_back(8'h00);
    put_text("x9");
    send_field();
    // field longer than the character limit
    for (i = 0; i < 70; i++) field_buf.push_back(8'("1" + (i % 9)));
    send_field();
    // every bit of the character code high
    field_buf.push_back(8'hFF);
    send_field();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_EXP;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits, sender mostly busy, receiver mostly stalled
    directed_fields();
    wait_drained(8);

    // widest limits
    program_limits(-1023, 1024);
    run_phase(11, 84, 540);
    wait_drained(8);

    // narrowest limits, sender mostly idle
    program_limits(0, 0);
    run_phase(84, 11, 540);
    wait_drained(8);

    // random limits, no idling on either side
    program_limits(-int'($urandom_range(1023)), int'($urandom_range(1024)));
    run_phase(0, 0, 540);
    wait_drained(20);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
